[hw/rtl/mms_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mms_pkg
// Shared types and codes of the small matrix multiplier.
// ----------------------------------------------------------------------------
package mms_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 3;
	localparam int DIM_W  = 4;
	localparam int OP_W   = 2;
	localparam int CFG_W  = 2;

	localparam logic [OP_W-1:0] OP_WR_A   = 2'd0;
	localparam logic [OP_W-1:0] OP_WR_B   = 2'd1;
	localparam logic [OP_W-1:0] OP_MULT   = 2'd2;

	localparam logic [CFG_W-1:0] CFG_ROWS_A = 2'd0;
	localparam logic [CFG_W-1:0] CFG_COLS_A = 2'd1;
	localparam logic [CFG_W-1:0] CFG_ROWS_B = 2'd2;
	localparam logic [CFG_W-1:0] CFG_COLS_B = 2'd3;

	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} mac_ctl_t;

endpackage : mms_pkg
`default_nettype wire

[hw/rtl/mms_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mms_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule : mms_ram
`default_nettype wire

[hw/rtl/mms_mac.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mms_mac
// Multiply-accumulate with exact wide sum, round half up and saturation.
// ----------------------------------------------------------------------------
module mms_mac import mms_pkg::*; #(
	parameter int MAX_DIM   = 8,
	parameter int FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mac_ctl_t          ctl,
	input  wire logic [DATA_W-1:0] a,
	input  wire logic [DATA_W-1:0] b,
	output logic                   res_vld,
	output logic      [DATA_W-1:0] res
);

	localparam int PW = 2 * DATA_W;
	localparam int AW = PW + $clog2(MAX_DIM) + 2;
	localparam logic signed [AW:0] HALF = (AW+1)'(1) <<< (FRAC_BITS - 1);

	mac_ctl_t                 ctl_s2;
	logic signed [PW-1:0]     prod_s2;
	logic signed [AW-1:0]     acc_q;
	logic                     done_q;
	logic                     res_vld_q;
	logic        [DATA_W-1:0] res_q;
	logic signed [AW-1:0]     prod_ext;
	logic signed [AW:0]       rnd;
	logic signed [AW:0]       shr;
	logic                     all_one;
	logic                     any_one;
	logic        [DATA_W-1:0] sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2    <= '0;
			done_q    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			ctl_s2    <= ctl;
			done_q    <= ctl_s2.vld && ctl_s2.last;
			res_vld_q <= done_q;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PW'($signed(a) * $signed(b));
		if (ctl_s2.vld) begin
			acc_q <= ctl_s2.first ? prod_ext : acc_q + prod_ext;
		end
		if (done_q) begin
			res_q <= sat;
		end
	end

	always_comb begin
		prod_ext = AW'(prod_s2);
		rnd      = (AW+1)'(acc_q) + HALF;
		shr      = rnd >>> FRAC_BITS;
		all_one  = &shr[AW:DATA_W-1];
		any_one  = |shr[AW:DATA_W-1];
		if (all_one || !any_one) begin
			sat = shr[DATA_W-1:0];
		end else if (shr[AW]) begin
			sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

	assign res_vld = res_vld_q;
	assign res     = res_q;

endmodule : mms_mac
`default_nettype wire

[hw/rtl/matrix_multiply_small.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_small
// Small dense Q-format matrix multiplier over two entry RAMs.
// ----------------------------------------------------------------------------
// Entry writes: one item per cycle while idle, no result.
// Compute: each product entry sums K products (K = inner length, 1 for a scalar
// operand) through the RAM read, multiply, accumulate, round and output stages;
// the first read of each later entry waits until the output register is empty.
// A dimension mismatch gives a single error result.
// One compute runs at a time; entry writes wait until it is done.
// Reset clears control and dimension registers (all 1); RAMs are not cleared.
// ----------------------------------------------------------------------------
module matrix_multiply_small import mms_pkg::*; #(
	parameter int MAX_DIM   = 8,
	parameter int FRAC_BITS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0] cfg_data,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [39:0]      s_axis_tdata,  // row_index, col_index, entry_value
	input  wire logic [OP_W-1:0]  s_axis_tuser,  // opcode
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic      [39:0]      m_axis_tdata,  // out_row, out_col, out_value
	output logic      [0:0]       m_axis_tuser,  // dim_error
	output logic                  m_axis_tlast
);

	localparam int IW    = $clog2(MAX_DIM);
	localparam int DEPTH = 1 << (2 * IW);
	localparam int RAW   = 2 * IW;
	localparam logic [DIM_W-1:0] DMAX = DIM_W'(MAX_DIM);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_ERR  = 2'd3;

	logic [DIM_W-1:0]  rows_a_q, cols_a_q, rows_b_q, cols_b_q;
	logic [DIM_W-1:0]  cfg_clamped;
	logic [1:0]        state_q;
	logic [IW-1:0]     i_q, j_q, k_q;
	mac_ctl_t          ctl, ctl_s1;

	logic              out_vld_q;
	logic [IDX_W-1:0]  out_row_q, out_col_q;
	logic [DATA_W-1:0] out_val_q;
	logic              out_last_q, out_err_q;

	logic [OP_W-1:0]   in_op;
	logic [IDX_W-1:0]  in_row, in_col;
	logic [DATA_W-1:0] in_val;
	logic              in_acc, out_acc, in_range;
	logic              a_we, b_we;
	logic [RAW-1:0]    waddr, a_raddr, b_raddr;
	logic [DATA_W-1:0] a_rdata, b_rdata;

	logic              a_scal, b_scal, mism;
	logic [DIM_W-1:0]  nr, nc, nk;
	logic [IW-1:0]     nr_m1, nc_m1, nk_m1;
	logic              issue, entry_last;
	logic              res_vld;
	logic [DATA_W-1:0] res;
	logic              err_load;

	assign in_op  = s_axis_tuser;
	assign in_row = s_axis_tdata[2:0];
	assign in_col = s_axis_tdata[5:3];
	assign in_val = s_axis_tdata[37:6];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_acc       = m_axis_tvalid && m_axis_tready;

	// configuration
	always_comb begin
		if (cfg_data == '0) begin
			cfg_clamped = DIM_W'(1);
		end else if (cfg_data > DMAX) begin
			cfg_clamped = DMAX;
		end else begin
			cfg_clamped = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= DIM_W'(1);
			cols_a_q <= DIM_W'(1);
			rows_b_q <= DIM_W'(1);
			cols_b_q <= DIM_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROWS_A: rows_a_q <= cfg_clamped;
				CFG_COLS_A: cols_a_q <= cfg_clamped;
				CFG_ROWS_B: rows_b_q <= cfg_clamped;
				CFG_COLS_B: cols_b_q <= cfg_clamped;
				default: ;
			endcase
		end
	end

	// operand shape
	always_comb begin
		a_scal = (rows_a_q == DIM_W'(1)) && (cols_a_q == DIM_W'(1));
		b_scal = (rows_b_q == DIM_W'(1)) && (cols_b_q == DIM_W'(1));
		mism   = !a_scal && !b_scal && (cols_a_q != rows_b_q);
		nr     = a_scal ? rows_b_q : rows_a_q;
		nc     = a_scal ? cols_b_q : (b_scal ? cols_a_q : cols_b_q);
		nk     = (a_scal || b_scal) ? DIM_W'(1) : cols_a_q;
		nr_m1  = IW'(nr - DIM_W'(1));
		nc_m1  = IW'(nc - DIM_W'(1));
		nk_m1  = IW'(nk - DIM_W'(1));
	end

	// entry stores
	assign in_range = (DIM_W'(in_row) < DMAX) && (DIM_W'(in_col) < DMAX);
	assign a_we     = in_acc && (in_op == OP_WR_A) && in_range;
	assign b_we     = in_acc && (in_op == OP_WR_B) && in_range;
	assign waddr    = {in_row[IW-1:0], in_col[IW-1:0]};

	always_comb begin
		if (a_scal) begin
			a_raddr = '0;
			b_raddr = {i_q, j_q};
		end else if (b_scal) begin
			a_raddr = {i_q, j_q};
			b_raddr = '0;
		end else begin
			a_raddr = {i_q, k_q};
			b_raddr = {k_q, j_q};
		end
	end

	mms_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_a_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (waddr),
		.wdata (in_val),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	mms_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_b_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (waddr),
		.wdata (in_val),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	// sequencer: hold the first read of an entry until the output is free
	assign issue      = (state_q == ST_RUN) && !((k_q == '0) && out_vld_q);
	assign entry_last = (i_q == nr_m1) && (j_q == nc_m1);
	assign err_load   = (state_q == ST_ERR) && !out_vld_q;

	always_comb begin
		ctl.vld   = issue;
		ctl.first = (k_q == '0);
		ctl.last  = (k_q == nk_m1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			ctl_s1  <= '0;
		end else begin
			ctl_s1 <= ctl;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (in_op == OP_MULT)) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= mism ? ST_ERR : ST_RUN;
					end
				end
				ST_RUN: begin
					if (issue) begin
						if (k_q == nk_m1) begin
							k_q     <= '0;
							state_q <= ST_WAIT;
						end else begin
							k_q <= k_q + IW'(1);
						end
					end
				end
				ST_WAIT: begin
					if (res_vld) begin
						if (entry_last) begin
							state_q <= ST_IDLE;
						end else begin
							if (j_q == nc_m1) begin
								j_q <= '0;
								i_q <= i_q + IW'(1);
							end else begin
								j_q <= j_q + IW'(1);
							end
							state_q <= ST_RUN;
						end
					end
				end
				ST_ERR: begin
					if (!out_vld_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	mms_mac #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_s1),
		.a       (a_rdata),
		.b       (b_rdata),
		.res_vld (res_vld),
		.res     (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			if (res_vld || err_load) begin
				out_vld_q <= 1'b1;
			end else if (out_acc) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld) begin
			out_row_q  <= IDX_W'(i_q);
			out_col_q  <= IDX_W'(j_q);
			out_val_q  <= res;
			out_last_q <= entry_last;
			out_err_q  <= 1'b0;
		end else if (err_load) begin
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_val_q  <= '0;
			out_last_q <= 1'b1;
			out_err_q  <= 1'b1;
		end
	end

	assign m_axis_tvalid   = out_vld_q;
	assign m_axis_tdata    = {2'b00, out_val_q, out_col_q, out_row_q};
	assign m_axis_tuser[0] = out_err_q;
	assign m_axis_tlast    = out_last_q;

	// checks
	a_res_free : assert property (@(posedge clk) disable iff (!arst_n)
		res_vld |-> !out_vld_q)
		else $error("product result arrived while output item still pending");

	a_res_wait : assert property (@(posedge clk) disable iff (!arst_n)
		res_vld |-> (state_q == ST_WAIT))
		else $error("product result outside of wait state");

	a_err_last : assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
		else $error("dimension error item not marked last");

	a_no_write_busy : assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s1.vld || res_vld) |-> !(a_we || b_we))
		else $error("entry write during compute");

endmodule : matrix_multiply_small
`default_nettype wire

[tb/sv/matrix_multiply_small_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_small_tb
// Self-checking bench for the small matrix multiplier: streams entry writes and
// computes into the block, predicts every product entry in fixed point and
// checks the result stream in order under random stalls on both sides.
// ----------------------------------------------------------------------------
module matrix_multiply_small_tb import mms_pkg::*;;

	localparam int MAX_D      = 8;
	localparam int FRAC       = 16;
	localparam int RAND_ITEMS = 190;
	localparam int TAIL       = 16;

	localparam logic [OP_W-1:0] OP_NOP = 2'd3;
	localparam logic signed [71:0] Q_MAX = 72'sd2147483647;
	localparam logic signed [71:0] Q_MIN = -72'sd2147483648;

	typedef struct packed {
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [DATA_W-1:0] value;
		logic              last;
		logic              dim_err;
	} prod_entry_t;

	class mm_product_board;
		logic [DATA_W-1:0] a_mem [0:MAX_D-1][0:MAX_D-1];
		logic [DATA_W-1:0] b_mem [0:MAX_D-1][0:MAX_D-1];
		logic [DIM_W-1:0]  dims [0:3];
		prod_entry_t       due[$];
		int n_items, n_computes, n_checked, n_dim_err, n_bad;

		function new();
			foreach (a_mem[i, j]) begin
				a_mem[i][j] = '0;
				b_mem[i][j] = '0;
			end
			foreach (dims[i]) dims[i] = 4'd1;
		endfunction

		function void set_dim(logic [CFG_W-1:0] idx, logic [DIM_W-1:0] val);
			dims[idx] = val;
		endfunction

		function int eff_dim(logic [DIM_W-1:0] d);
			if (d == 0) return 1;
			if (d > MAX_D) return MAX_D;
			return d;
		endfunction

		function logic signed [71:0] wide_mul(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y);
			logic signed [63:0] p;
			p = $signed(x) * $signed(y);
			return p;
		endfunction

		function logic [DATA_W-1:0] round_sat(logic signed [71:0] s);
			logic signed [71:0] r;
			r = (s + (72'sd1 <<< (FRAC - 1))) >>> FRAC;
			if (r > Q_MAX) return 32'h7FFF_FFFF;
			if (r < Q_MIN) return 32'h8000_0000;
			return r[31:0];
		endfunction

		function void predict_product();
			int ra, ca, rb, cb, nr, nc;
			logic signed [71:0] acc;
			prod_entry_t e;
			ra = eff_dim(dims[CFG_ROWS_A]);
			ca = eff_dim(dims[CFG_COLS_A]);
			rb = eff_dim(dims[CFG_ROWS_B]);
			cb = eff_dim(dims[CFG_COLS_B]);
			n_computes++;
			if (ra == 1 && ca == 1) begin
				nr = rb;
				nc = cb;
			end else if (rb == 1 && cb == 1) begin
				nr = ra;
				nc = ca;
			end else if (ca != rb) begin
				e = '0;
				e.last = 1'b1;
				e.dim_err = 1'b1;
				due.push_back(e);
				return;
			end else begin
				nr = ra;
				nc = cb;
			end
			for (int i = 0; i < nr; i++) begin
				for (int j = 0; j < nc; j++) begin
					acc = '0;
					if (ra == 1 && ca == 1)
						acc = wide_mul(a_mem[0][0], b_mem[i][j]);
					else if (rb == 1 && cb == 1)
						acc = wide_mul(a_mem[i][j], b_mem[0][0]);
					else
						for (int k = 0; k < ca; k++)
							acc = acc + wide_mul(a_mem[i][k], b_mem[k][j]);
					e.row = i[IDX_W-1:0];
					e.col = j[IDX_W-1:0];
					e.value = round_sat(acc);
					e.last = (i == nr - 1) && (j == nc - 1);
					e.dim_err = 1'b0;
					due.push_back(e);
				end
			end
		endfunction

		function void take_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] r,
				logic [IDX_W-1:0] c, logic [DATA_W-1:0] v);
			n_items++;
			case (op)
				OP_WR_A: a_mem[r][c] = v;
				OP_WR_B: b_mem[r][c] = v;
				OP_MULT: predict_product();
				default: ;
			endcase
		endfunction

		function void check_entry(prod_entry_t got);
			prod_entry_t want;
			if (due.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected product entry: r%0d c%0d %h last %b err %b",
						got.row, got.col, got.value, got.last, got.dim_err);
				return;
			end
			want = due.pop_front();
			n_checked++;
			if (want.dim_err) n_dim_err++;
			if (got.row !== want.row || got.col !== want.col || got.value !== want.value ||
					got.last !== want.last || got.dim_err !== want.dim_err) begin
				n_bad++;
				if (n_bad <= 10) begin
					$display("product entry mismatch: want r%0d c%0d %h last %b err %b",
						want.row, want.col, want.value, want.last, want.dim_err);
					$display("                        got  r%0d c%0d %h last %b err %b",
						got.row, got.col, got.value, got.last, got.dim_err);
				end
			end
		endfunction
	endclass

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              cfg_we        = 1'b0;
	logic [CFG_W-1:0]  cfg_index     = '0;
	logic [DIM_W-1:0]  cfg_data      = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [39:0]       s_axis_tdata  = '0;  // row_index, col_index, entry_value
	logic [OP_W-1:0]   s_axis_tuser  = '0;  // opcode
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [39:0]       m_axis_tdata;        // out_row, out_col, out_value
	logic [0:0]        m_axis_tuser;        // dim_error
	logic              m_axis_tlast;

	mm_product_board board = new();
	int send_idle = 6;
	int recv_idle = 52;
	int n_sent = 0;
	bit a_set [0:MAX_D-1][0:MAX_D-1];
	bit b_set [0:MAX_D-1][0:MAX_D-1];

	matrix_multiply_small #(
		.MAX_DIM  (MAX_D),
		.FRAC_BITS(FRAC)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			board.take_item(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[5:3],
				s_axis_tdata[37:6]);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_entry({m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tdata[37:6],
				m_axis_tlast, m_axis_tuser[0]});
	end

	function automatic logic [DATA_W-1:0] rand_entry();
		logic [31:0] x;
		x = $urandom;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					3: return 32'hFFFF_FFFF;
					default: return 32'h0001_0000;
				endcase
			end
			1, 2: return x;
			default: return {{12{x[19]}}, x[19:0]};
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] dim_code(int d);
		if (d == 1 && $urandom_range(3) == 0) return 4'd0;
		if (d == MAX_D && $urandom_range(1) == 0) return 4'($urandom_range(15, 9));
		return 4'(d);
	endfunction

	function automatic int pick_dim();
		if ($urandom_range(19) == 0) return $urandom_range(MAX_D, 1);
		return $urandom_range(3, 1);
	endfunction

	task automatic push_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] val);
		if ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {2'b00, val, col, row};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (op == OP_WR_A) a_set[row][col] = 1'b1;
		if (op == OP_WR_B) b_set[row][col] = 1'b1;
		n_sent++;
	endtask

	task automatic push_noise();
		if ($urandom_range(1) == 0)
			push_item(OP_NOP, 3'($urandom_range(7)), 3'($urandom_range(7)), $urandom);
		else
			push_item($urandom_range(1) ? OP_WR_B : OP_WR_A, 3'($urandom_range(7)),
				3'($urandom_range(7)), rand_entry());
	endtask

	// drop valid and hold until every predicted entry has come back
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (board.due.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
	endtask

	task automatic load_dims(input logic [DIM_W-1:0] ra, input logic [DIM_W-1:0] ca,
			input logic [DIM_W-1:0] rb, input logic [DIM_W-1:0] cb);
		logic [DIM_W-1:0] vals [0:3];
		vals = '{ra, ca, rb, cb};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= 2'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			board.set_dim(2'(i), vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic fill_store(input logic [OP_W-1:0] op, input int nr, input int nc);
		bit done;
		for (int i = 0; i < nr; i++) begin
			for (int j = 0; j < nc; j++) begin
				done = (op == OP_WR_A) ? a_set[i][j] : b_set[i][j];
				if (!done || $urandom_range(9) < 7)
					push_item(op, 3'(i), 3'(j), rand_entry());
				if ($urandom_range(99) < 8)
					push_noise();
			end
		end
	endtask

	task automatic run_job(input int ra, input int ca, input int rb, input int cb);
		int ar, ac, br, bc;
		settle();
		load_dims(dim_code(ra), dim_code(ca), dim_code(rb), dim_code(cb));
		if (ra == 1 && ca == 1) begin
			ar = 1; ac = 1; br = rb; bc = cb;
		end else if (rb == 1 && cb == 1) begin
			ar = ra; ac = ca; br = 1; bc = 1;
		end else if (ca != rb) begin
			ar = 0; ac = 0; br = 0; bc = 0;
		end else begin
			ar = ra; ac = ca; br = rb; bc = cb;
		end
		fill_store(OP_WR_A, ar, ac);
		fill_store(OP_WR_B, br, bc);
		push_item(OP_MULT, 3'($urandom_range(7)), 3'($urandom_range(7)), $urandom);
		if ($urandom_range(9) < 4) begin
			repeat ($urandom_range(3, 1)) begin
				if (ar > 0 && $urandom_range(1) == 0)
					push_item(OP_WR_A, 3'($urandom_range(ar - 1)),
						3'($urandom_range(ac - 1)), rand_entry());
				else if (br > 0)
					push_item(OP_WR_B, 3'($urandom_range(br - 1)),
						3'($urandom_range(bc - 1)), rand_entry());
				else
					push_noise();
			end
			push_item(OP_MULT, 3'($urandom_range(7)), 3'($urandom_range(7)), $urandom);
		end
	endtask

	initial begin
		int dir_sent, job, phase, kind, kk;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// scalar saturation, ignored opcode, rounding at one half
		push_item(OP_WR_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
		push_item(OP_WR_B, 3'd0, 3'd0, 32'h8000_0000);
		push_item(OP_MULT, 3'd0, 3'd0, 32'h0);
		push_item(OP_NOP, 3'd7, 3'd7, 32'hFFFF_FFFF);
		push_item(OP_WR_A, 3'd0, 3'd0, 32'h8000_0000);
		push_item(OP_MULT, 3'd7, 3'd7, 32'hFFFF_FFFF);
		push_item(OP_WR_B, 3'd0, 3'd0, 32'h0000_8000);
		push_item(OP_WR_A, 3'd0, 3'd0, 32'h0000_0001);
		push_item(OP_MULT, 3'd0, 3'd0, 32'h0);
		push_item(OP_WR_A, 3'd0, 3'd0, 32'hFFFF_FFFF);
		push_item(OP_MULT, 3'd0, 3'd0, 32'h0);
		push_item(OP_WR_A, 3'd7, 3'd7, $urandom);
		push_item(OP_WR_B, 3'd7, 3'd7, $urandom);
		// inner dimension mismatch
		settle();
		load_dims(4'd2, 4'd3, 4'd2, 4'd5);
		push_item(OP_MULT, 3'd0, 3'd0, 32'h0);
		// zero registers act as one: scalar A times a 2x1 B
		settle();
		load_dims(4'd0, 4'd0, 4'd2, 4'd0);
		push_item(OP_WR_B, 3'd1, 3'd0, 32'hFFFF_0000);
		push_item(OP_MULT, 3'd0, 3'd0, 32'h0);
		// oversize register clamps: 1x8 A scaled by scalar B
		settle();
		load_dims(4'd1, 4'd15, 4'd0, 4'd1);
		for (int j = 1; j < MAX_D; j++)
			push_item(OP_WR_A, 3'd0, 3'(j), rand_entry());
		push_item(OP_MULT, 3'd0, 3'd0, 32'h0);
		dir_sent = n_sent;

		job = 0;
		while (n_sent < dir_sent + RAND_ITEMS) begin
			phase = (n_sent - dir_sent) * 3 / RAND_ITEMS;
			case (phase)
				0: begin send_idle = 6;  recv_idle = 52; end
				1: begin send_idle = 52; recv_idle = 6;  end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			case (job)
				2: run_job(MAX_D, MAX_D, 1, 1);
				6: run_job(2, MAX_D, MAX_D, 3);
				10: run_job(1, 1, MAX_D, 2);
				default: begin
					kind = $urandom_range(99);
					if (kind < 45) begin
						kk = pick_dim();
						run_job(pick_dim(), kk, kk, pick_dim());
					end else if (kind < 62) begin
						run_job(1, 1, pick_dim(), pick_dim());
					end else if (kind < 79) begin
						run_job(pick_dim(), pick_dim(), 1, 1);
					end else begin
						kk = $urandom_range(MAX_D, 1);
						do kind = $urandom_range(MAX_D, 1); while (kind == kk);
						run_job($urandom_range(MAX_D, 2), kk, kind, $urandom_range(MAX_D, 2));
					end
				end
			endcase
			job++;
		end
		settle();

		$display("ran %0d items with %0d computes over %0d dimension settings",
			board.n_items, board.n_computes, job + 3);
		$display("checked %0d product entries, %0d of them dimension errors",
			board.n_checked, board.n_dim_err);
		if (board.n_bad == 0 && board.due.size() == 0)
			$display("matrix_multiply_small regression: pass");
		else
			$display("matrix_multiply_small regression: fail");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("matrix_multiply_small regression: fail");
		$finish;
	end

endmodule
